/* hw/rtl/lpg_pkg.sv */
package lpg_pkg;

	// Default coordinate width, used by the top level parameter
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths
	localparam int LEVEL_W   = 8;
	localparam int PITCH_W   = 14;
	localparam int BPP_W     = 3;
	localparam int DIM_W     = 11;
	localparam int OFFSET_W  = 26;
	localparam int COLOR_W   = 3 * LEVEL_W;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 3;

	// Register reset values
	localparam logic [LEVEL_W-1:0] RED_RST    = 8'd255;
	localparam logic [LEVEL_W-1:0] GREEN_RST  = 8'd255;
	localparam logic [LEVEL_W-1:0] BLUE_RST   = 8'd255;
	localparam logic [PITCH_W-1:0] PITCH_RST  = 14'd7680;
	localparam logic [BPP_W-1:0]   BPP_RST    = 3'd4;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1920;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1080;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED    = 3'd0,
		REG_GREEN  = 3'd1,
		REG_BLUE   = 3'd2,
		REG_PITCH  = 3'd3,
		REG_BPP    = 3'd4,
		REG_WIDTH  = 3'd5,
		REG_HEIGHT = 3'd6
	} cfg_reg_t;

	// Input item kinds
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [PITCH_W-1:0] pitch;
		logic [BPP_W-1:0]   bpp;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
	} cfg_t;

endpackage

/* hw/rtl/lpg_cfg_regs.sv */
module lpg_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpg_pkg::CFG_W-1:0]       cfg_data,
	output lpg_pkg::cfg_t                   cfg
);
	import lpg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red    <= RED_RST;
			cfg_q.green  <= GREEN_RST;
			cfg_q.blue   <= BLUE_RST;
			cfg_q.pitch  <= PITCH_RST;
			cfg_q.bpp    <= BPP_RST;
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED:    cfg_q.red    <= cfg_data[LEVEL_W-1:0];
				REG_GREEN:  cfg_q.green  <= cfg_data[LEVEL_W-1:0];
				REG_BLUE:   cfg_q.blue   <= cfg_data[LEVEL_W-1:0];
				REG_PITCH:  cfg_q.pitch  <= cfg_data[PITCH_W-1:0];
				REG_BPP:    cfg_q.bpp    <= cfg_data[BPP_W-1:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[DIM_W-1:0];
				default:    ;  // unused index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/lpg_stepper.sv */
module lpg_stepper #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         tick,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         active,
	output logic signed [COORD_BITS-1:0] cur_x,
	output logic signed [COORD_BITS-1:0] cur_y,
	output logic                         at_end
);
	import lpg_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int ERR_W  = COORD_BITS + 2;
	localparam int E2_W   = COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic                         neg_x_q, neg_y_q, active_q;
	logic [COORD_BITS-1:0]        dx_q;
	logic signed [DIFF_W-1:0]     dyn_q;
	logic signed [ERR_W-1:0]      err_q;

	// Load path
	logic signed [DIFF_W-1:0] ddx, ddy, ddx_abs, dyn_ld;
	logic signed [ERR_W-1:0]  err_ld;

	assign ddx     = DIFF_W'(end_x) - DIFF_W'(start_x);
	assign ddy     = DIFF_W'(end_y) - DIFF_W'(start_y);
	assign ddx_abs = ddx[DIFF_W-1] ? -ddx : ddx;
	assign dyn_ld  = ddy[DIFF_W-1] ? ddy : -ddy;
	assign err_ld  = ERR_W'(ddx_abs) + ERR_W'(dyn_ld);

	// Step path
	logic signed [E2_W-1:0]  e2, dyn_e, dx_e;
	logic                    go_x, go_y;
	logic signed [ERR_W-1:0] err_step;

	assign at_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign e2     = {E2_W'(err_q)} <<< 1;
	assign dyn_e  = E2_W'(dyn_q);
	assign dx_e   = $signed(E2_W'(dx_q));
	assign go_x   = e2 >= dyn_e;
	assign go_y   = e2 <= dx_e;
	assign err_step = err_q + (go_x ? ERR_W'(dyn_q) : '0)
		+ (go_y ? $signed(ERR_W'(dx_q)) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			dx_q     <= '0;
			dyn_q    <= '0;
			err_q    <= '0;
			active_q <= 1'b0;
		end else if (load) begin
			cur_x_q  <= start_x;
			cur_y_q  <= start_y;
			tgt_x_q  <= end_x;
			tgt_y_q  <= end_y;
			neg_x_q  <= !(start_x < end_x);
			neg_y_q  <= !(start_y < end_y);
			dx_q     <= ddx_abs[COORD_BITS-1:0];
			dyn_q    <= dyn_ld;
			err_q    <= err_ld;
			active_q <= 1'b1;
		end else if (tick && active_q) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_step;
				if (go_x)
					cur_x_q <= neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				if (go_y)
					cur_y_q <= neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
		end
	end

	assign active = active_q;
	assign cur_x  = cur_x_q;
	assign cur_y  = cur_y_q;

	a_load_arms: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> active_q)
		else $error("line not active after load");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !load && active_q && at_end) |=> !active_q)
		else $error("line still active after its end point");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !load && active_q && !at_end) |=>
		!(cur_x_q == $past(cur_x_q) && cur_y_q == $past(cur_y_q)))
		else $error("step left the pixel in place");

endmodule

/* hw/rtl/lpg_pixel_map.sv */
module lpg_pixel_map #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  lpg_pkg::cfg_t                   cfg,
	input  logic signed [COORD_BITS-1:0]    cur_x,
	input  logic signed [COORD_BITS-1:0]    cur_y,
	output logic                            in_bounds,
	output logic [lpg_pkg::OFFSET_W-1:0]    byte_offset,
	output logic [lpg_pkg::COLOR_W-1:0]     pixel_color
);
	import lpg_pkg::*;

	localparam int MAG_W  = COORD_BITS - 1;
	localparam int CMP_W  = (MAG_W > DIM_W) ? MAG_W : DIM_W;
	localparam int ROW_W  = MAG_W + PITCH_W;
	localparam int COL_W  = MAG_W + BPP_W;

	logic [MAG_W-1:0] x_mag, y_mag;
	logic [ROW_W-1:0] row_off;
	logic [COL_W-1:0] col_off;
	logic [OFFSET_W-1:0] sum_off;

	assign x_mag = cur_x[MAG_W-1:0];
	assign y_mag = cur_y[MAG_W-1:0];

	assign in_bounds = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
		&& (CMP_W'(x_mag) < CMP_W'(cfg.width))
		&& (CMP_W'(y_mag) < CMP_W'(cfg.height));

	assign row_off = ROW_W'(y_mag) * ROW_W'(cfg.pitch);
	assign col_off = COL_W'(x_mag) * COL_W'(cfg.bpp);
	// wraps at the offset width
	assign sum_off = OFFSET_W'(row_off) + OFFSET_W'(col_off);

	assign byte_offset = in_bounds ? sum_off : '0;
	assign pixel_color = {cfg.red, cfg.green, cfg.blue};

endmodule

/* hw/rtl/line_pixel_generator.sv */
// Bresenham line pixel generator. A load item (tuser = 0) carries the signed
// start and end points of a line and produces nothing; each tick item
// (tuser = 1) on an active line produces the current pixel and advances one
// Bresenham step, and the pixel that is the end point comes with tlast set,
// after which the block is idle and ticks produce nothing until the next
// load. A load while a line is running replaces it. Each pixel carries its
// coordinates, an in-bounds flag from clipping against screen_width and
// screen_height, the framebuffer byte offset y*row_pitch + x*bytes_per_pixel
// (wrapped to 26 bits, zero when clipped) and the packed drawing color.
// Rate: one item per clock, sustained. An item waits in the input register
// and its pixel is written to the output register when the item advances,
// which raises tvalid; only a stalled output (m_axis_tready low while a
// pixel waits) holds up the input side, and items that produce no pixel pass
// even then. Configuration registers are written through cfg_we/cfg_index/
// cfg_data and take effect at once; write them only while no item is in
// flight.
module line_pixel_generator #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 1 + lpg_pkg::OFFSET_W
		+ lpg_pkg::COLOR_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: start_x, start_y, end_x, end_y
	input  logic [IN_W-1:0]               s_axis_tdata,
	// tuser: mode
	input  logic                          s_axis_tuser,
	// master side
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: pixel_x, pixel_y, in_bounds, byte_offset, pixel_color
	output logic [OUT_W-1:0]              m_axis_tdata,
	output logic                          m_axis_tlast,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpg_pkg::CFG_W-1:0]     cfg_data
);
	import lpg_pkg::*;

	localparam int C = COORD_BITS;

	cfg_t cfg;

	lpg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	logic                valid_s1;
	logic                mode_s1;
	logic signed [C-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic                adv_s1, emit_s1;

	logic                active, at_end;
	logic signed [C-1:0] cur_x, cur_y;

	// A tick on an active line is the only item that needs output room.
	assign emit_s1 = valid_s1 && (mode_s1 == MODE_TICK) && active;
	assign adv_s1  = valid_s1 && (!emit_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1    <= s_axis_tuser;
			start_x_s1 <= s_axis_tdata[C-1:0];
			start_y_s1 <= s_axis_tdata[2*C-1:C];
			end_x_s1   <= s_axis_tdata[3*C-1:2*C];
			end_y_s1   <= s_axis_tdata[4*C-1:3*C];
		end
	end

	// Line state and the Bresenham step
	lpg_stepper #(.COORD_BITS(COORD_BITS)) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv_s1 && (mode_s1 == MODE_LOAD)),
		.tick    (adv_s1 && (mode_s1 == MODE_TICK)),
		.start_x (start_x_s1),
		.start_y (start_y_s1),
		.end_x   (end_x_s1),
		.end_y   (end_y_s1),
		.active  (active),
		.cur_x   (cur_x),
		.cur_y   (cur_y),
		.at_end  (at_end)
	);

	// Clipping, byte offset and color of the current pixel
	logic                in_bounds;
	logic [OFFSET_W-1:0] byte_offset;
	logic [COLOR_W-1:0]  pixel_color;

	lpg_pixel_map #(.COORD_BITS(COORD_BITS)) u_map (
		.cfg         (cfg),
		.cur_x       (cur_x),
		.cur_y       (cur_y),
		.in_bounds   (in_bounds),
		.byte_offset (byte_offset),
		.pixel_color (pixel_color)
	);

	// Output register: hold the pixel until it is taken
	logic                out_valid_q;
	logic signed [C-1:0] pix_x_q, pix_y_q;
	logic                in_bounds_q, last_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [COLOR_W-1:0]  color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && emit_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			pix_x_q     <= cur_x;
			pix_y_q     <= cur_y;
			in_bounds_q <= in_bounds;
			offset_q    <= byte_offset;
			color_q     <= pixel_color;
			last_q      <= at_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({color_q, offset_q, in_bounds_q, pix_y_q, pix_x_q});
	assign m_axis_tlast  = last_q;

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lpg_pkg::*;

	localparam int CB    = COORD_BITS_DEF;
	localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CB + 1 + OFFSET_W + COLOR_W + 7) / 8) * 8;

	// Bit positions of the pixel fields in m_axis_tdata
	localparam int PY_LO  = CB;
	localparam int VIS_BIT = 2 * CB;
	localparam int OFS_LO = 2 * CB + 1;
	localparam int COL_LO = OFS_LO + OFFSET_W;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 8;    // two register stages, with margin
	localparam int HOLD_CYCLES  = 400;
	localparam int LINE_TO_END  = 8192; // longer than any line can be
	localparam int IDLE_PCT     = 35;

	typedef struct packed {
		logic [CB-1:0]       px;
		logic [CB-1:0]       py;
		logic                in_view;
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0]  color;
		logic                is_last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              s_axis_tuser = MODE_TICK;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	// Drawing settings as the block should hold them
	logic [LEVEL_W-1:0] lvl_red   = RED_RST;
	logic [LEVEL_W-1:0] lvl_green = GREEN_RST;
	logic [LEVEL_W-1:0] lvl_blue  = BLUE_RST;
	logic [PITCH_W-1:0] row_bytes = PITCH_RST;
	logic [BPP_W-1:0]   pix_bytes = BPP_RST;
	logic [DIM_W-1:0]   scr_w     = WIDTH_RST;
	logic [DIM_W-1:0]   scr_h     = HEIGHT_RST;

	// Rasterizer state: pen position, end point, directions, deltas, error
	int   pen_x = 0, pen_y = 0, goal_x = 0, goal_y = 0;
	logic x_back = 1'b0, y_back = 1'b0;
	int   span_x = 0, span_y_neg = 0, err_acc = 0;
	logic line_on = 1'b0;

	pixel_t pending_pixels[$];

	int  errors = 0;
	int  cycle_count = 0;
	int  items_counted = 0;
	int  rx_hold_left = 0;
	logic tx_no_idle = 1'b0;
	logic rx_no_idle = 1'b0;

	line_pixel_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),    // start_x, start_y, end_x, end_y
		.s_axis_tuser(s_axis_tuser),    // mode
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),    // pixel_x, pixel_y, in_bounds, byte_offset, pixel_color
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bound the run; a hang anywhere ends here
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Receiver: hold off when asked, else run flat out or idle at random
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Advance the expected rasterizer by one accepted item; queue the pixel
	// that a tick on an active line produces.
	function automatic void step_rasterizer(input logic mode, input logic [IN_W-1:0] data);
		int x0, y0, x1, y1, e2;
		logic in_view;
		longint unsigned ofs;
		pixel_t p;
		if (mode == MODE_LOAD) begin
			x0 = int'($signed(data[CB-1:0]));
			y0 = int'($signed(data[2*CB-1:CB]));
			x1 = int'($signed(data[3*CB-1:2*CB]));
			y1 = int'($signed(data[4*CB-1:3*CB]));
			pen_x = x0;
			pen_y = y0;
			goal_x = x1;
			goal_y = y1;
			x_back = !(x0 < x1);
			y_back = !(y0 < y1);
			span_x = (x1 - x0 < 0) ? x0 - x1 : x1 - x0;
			span_y_neg = (y1 - y0 < 0) ? y1 - y0 : y0 - y1;
			err_acc = span_x + span_y_neg;
			line_on = 1'b1;
			return;
		end
		// ticks on an idle block are dropped
		if (!line_on)
			return;
		in_view = pen_x >= 0 && pen_y >= 0 && pen_x < int'(scr_w) && pen_y < int'(scr_h);
		ofs = 0;
		if (in_view)
			ofs = longint'(pen_y) * longint'(row_bytes) + longint'(pen_x) * longint'(pix_bytes);
		p.px = pen_x[CB-1:0];
		p.py = pen_y[CB-1:0];
		p.in_view = in_view;
		p.offset = ofs[OFFSET_W-1:0];
		p.color = {lvl_red, lvl_green, lvl_blue};
		p.is_last = (pen_x == goal_x) && (pen_y == goal_y);
		pending_pixels.push_back(p);
		if (p.is_last) begin
			line_on = 1'b0;
		end else begin
			e2 = 2 * err_acc;
			if (e2 >= span_y_neg) begin
				err_acc = err_acc + span_y_neg;
				pen_x = x_back ? pen_x - 1 : pen_x + 1;
			end
			if (e2 <= span_x) begin
				err_acc = err_acc + span_x;
				pen_y = y_back ? pen_y - 1 : pen_y + 1;
			end
		end
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	// Checker: sample at the falling edge, where the handshake lines are
	// settled; a pixel seen here is taken at the next rising edge.
	always @(negedge clk) begin : pixel_checker
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: pixel with none expected, expected none, got x=%0d y=%0d",
					$time, $signed(m_axis_tdata[CB-1:0]), $signed(m_axis_tdata[2*CB-1:PY_LO]));
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.px, m_axis_tdata[CB-1:0]);
				check_field("pixel_y", want.py, m_axis_tdata[2*CB-1:PY_LO]);
				check_field("in_bounds", want.in_view, m_axis_tdata[VIS_BIT]);
				check_field("byte_offset", want.offset, m_axis_tdata[COL_LO-1:OFS_LO]);
				check_field("pixel_color", want.color, m_axis_tdata[COL_LO+COLOR_W-1:COL_LO]);
				check_field("last", want.is_last, m_axis_tlast);
			end
		end
	end

	// Offer one item and hold it until taken. Starts and ends at a rising
	// edge; tvalid stays high on return so back-to-back items run at full rate.
	task automatic send_item(input logic mode, input logic [IN_W-1:0] data);
		logic taken;
		while (!tx_no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= data;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_axis_tready;
			// the item goes in at the coming edge: predict now
			if (taken) begin
				if (mode == MODE_LOAD || line_on)
					items_counted++;
				step_rasterizer(mode, data);
			end
			@(posedge clk);
		end
	endtask

	task automatic load_line(input int sx, input int sy, input int ex, input int ey);
		logic [IN_W-1:0] d;
		d = '0;
		d[CB-1:0] = sx[CB-1:0];
		d[2*CB-1:CB] = sy[CB-1:0];
		d[3*CB-1:2*CB] = ex[CB-1:0];
		d[4*CB-1:3*CB] = ey[CB-1:0];
		send_item(MODE_LOAD, d);
	endtask

	// Ticks carry junk in tdata; the block must ignore it
	task automatic tick();
		logic [IN_W-1:0] d;
		d = IN_W'({$urandom, $urandom});
		send_item(MODE_TICK, d);
	endtask

	// Load a line and tick it up to max_ticks times or until its end point
	task automatic trace_line(input int sx, input int sy, input int ex, input int ey,
		input int max_ticks);
		int n;
		load_line(sx, sy, ex, ey);
		n = 0;
		while (line_on && n < max_ticks) begin
			tick();
			n++;
		end
	endtask

	// Drop tvalid, let every pixel come out, then let the pipe empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RED:    lvl_red = val[LEVEL_W-1:0];
			REG_GREEN:  lvl_green = val[LEVEL_W-1:0];
			REG_BLUE:   lvl_blue = val[LEVEL_W-1:0];
			REG_PITCH:  row_bytes = val[PITCH_W-1:0];
			REG_BPP:    pix_bytes = val[BPP_W-1:0];
			REG_WIDTH:  scr_w = val[DIM_W-1:0];
			REG_HEIGHT: scr_h = val[DIM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int r, input int g, input int b, input int pitch,
		input int bpp, input int w, input int h);
		write_reg(REG_RED, r[CFG_W-1:0]);
		write_reg(REG_GREEN, g[CFG_W-1:0]);
		write_reg(REG_BLUE, b[CFG_W-1:0]);
		write_reg(REG_PITCH, pitch[CFG_W-1:0]);
		write_reg(REG_BPP, bpp[CFG_W-1:0]);
		write_reg(REG_WIDTH, w[CFG_W-1:0]);
		write_reg(REG_HEIGHT, h[CFG_W-1:0]);
	endtask

	function automatic int clamp_coord(input int v);
		if (v < -(1 << (CB - 1)))
			return -(1 << (CB - 1));
		if (v > (1 << (CB - 1)) - 1)
			return (1 << (CB - 1)) - 1;
		return v;
	endfunction

	function automatic int rand_coord();
		logic [CB-1:0] r;
		r = CB'($urandom);
		return int'($signed(r));
	endfunction

	// A coordinate from a little below zero to a little beyond the visible span
	function automatic int near_edge(input int span);
		return clamp_coord(int'($urandom_range(0, span + 16)) - 8);
	endfunction

	function automatic int nudge(input int v);
		return clamp_coord(v + int'($urandom_range(0, 24)) - 12);
	endfunction

	// Mostly whole short lines with random content; the rest aborted lines,
	// stray ticks and single points followed by ticks on an idle block.
	task automatic random_lines(input int target);
		int stop_at, sx, sy, pick;
		stop_at = items_counted + target;
		while (items_counted < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				sx = near_edge(int'(scr_w));
				sy = near_edge(int'(scr_h));
				trace_line(sx, sy, nudge(sx), nudge(sy), LINE_TO_END);
			end else if (pick < 75) begin
				sx = rand_coord();
				sy = rand_coord();
				trace_line(sx, sy, nudge(sx), nudge(sy), LINE_TO_END);
			end else if (pick < 85) begin
				// long line, cut short by whatever loads next
				trace_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					$urandom_range(0, 12));
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4)) tick();
			end else begin
				sx = near_edge(int'(scr_w));
				sy = near_edge(int'(scr_h));
				trace_line(sx, sy, sx, sy, LINE_TO_END);
				repeat ($urandom_range(1, 2)) tick();
			end
		end
	endtask

	// Reset settings: idle ticks, single points, corners of the coordinate
	// range, edge clipping, steep and shallow lines, and a load that replaces
	// a running line.
	task automatic test_directed_defaults();
		tick();
		trace_line(5, 7, 5, 7, LINE_TO_END);
		tick();
		trace_line(2047, 2047, 2047, 2047, LINE_TO_END);
		trace_line(-2048, -2048, -2048, -2048, LINE_TO_END);
		trace_line(-1, -1, 1, 0, LINE_TO_END);
		trace_line(1919, 1079, 1920, 1077, LINE_TO_END);
		trace_line(-2048, 2047, 2047, -2048, 2);
		trace_line(3, 0, 0, 3, LINE_TO_END);
	endtask

	// All-ones writes (masked to each register's width), all zeros (every
	// pixel clipped), then the smallest useful screen.
	task automatic test_register_extremes();
		wait_drained();
		write_all(16383, 16383, 16383, 16383, 16383, 16383, 16383);
		trace_line(2040, 2046, 2046, 2040, LINE_TO_END);
		random_lines(30);
		wait_drained();
		write_all(0, 0, 0, 0, 0, 0, 0);
		random_lines(30);
		wait_drained();
		write_all(0, 255, 0, 1, 1, 1, 1);
		random_lines(30);
	endtask

	task automatic test_random_settings();
		int pitch, bpp, w, h;
		repeat (5) begin
			wait_drained();
			pitch = ($urandom_range(9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 16383);
			bpp = ($urandom_range(4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			w = ($urandom_range(2) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 2047);
			h = ($urandom_range(2) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 2047);
			write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				pitch, bpp, w, h);
			random_lines(100);
		end
	endtask

	// Stall the output for a long stretch while items keep coming, so the
	// block backs up and drops tready on its input.
	task automatic test_output_hold_off();
		wait_drained();
		tx_no_idle = 1'b1;
		rx_hold_left = HOLD_CYCLES;
		random_lines(150);
		tx_no_idle = 1'b0;
	endtask

	task automatic test_full_rate();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		random_lines(120);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_register_extremes();
		test_random_settings();
		test_output_hold_off();
		test_full_rate();
		wait_drained();
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
